/* hw/rtl/qvc_pkg.sv */
// Shared types, constants and the phase transition table for the volume control.
`timescale 1ns / 1ps
package qvc_pkg;

  localparam int VOL_W     = 16;
  localparam int PCT_W     = 7;
  localparam int PROD_W    = VOL_W + PCT_W;
  localparam int CNT_W     = 5;
  localparam int THR_W     = 4;
  localparam int OP_W      = 2;
  localparam int LVL_W     = 2;
  localparam int DIR_W     = 2;
  localparam int PHASE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int MUL_CNT_W = $clog2(PCT_W);
  localparam int DIV_CNT_W = $clog2(PROD_W);

  localparam logic [PCT_W-1:0] PERCENT_SCALE = PCT_W'(100);
  localparam logic [PCT_W-1:0] PERCENT_LIMIT = PCT_W'(127);
  localparam logic [PCT_W-1:0] UNIT_FACTOR   = PCT_W'(1);

  localparam logic [VOL_W-1:0] VOLUME_MAX_RST     = VOL_W'(255);
  localparam logic [THR_W-1:0] STEP_THRESHOLD_RST = THR_W'(4);
  localparam logic [VOL_W-1:0] INITIAL_VOLUME_RST = VOL_W'(0);

  localparam logic [OP_W-1:0] OP_PIN_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_PIN_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_BUTTON = 2'd2;

  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_MAX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VOLUME = 2'd2;

  localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
  localparam logic signed [DIR_W-1:0] DIR_UP   = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_DN   = 2'sb11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_STEP_UP,
    ACT_STEP_DN,
    ACT_MUTE,
    ACT_UNMUTE
  } action_t;

  typedef struct packed {
    logic             start;
    logic [VOL_W-1:0] multiplicand;
    logic [PCT_W-1:0] multiplier;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [VOL_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

  // Index is {old phase, new phase}; zero marks an invalid or absent move.
  function automatic logic signed [DIR_W-1:0] move_lookup(input logic [2*PHASE_W-1:0] idx);
    logic signed [DIR_W-1:0] mv;
    unique case (idx) inside
      4'd1, 4'd7, 4'd8, 4'd14:  mv = DIR_DN;
      4'd2, 4'd4, 4'd11, 4'd13: mv = DIR_UP;
      default:                  mv = DIR_NONE;
    endcase
    return mv;
  endfunction

endpackage

/* hw/rtl/qvc_if.sv */
// Valid/ready channel interfaces for pin events, results and register writes.
`timescale 1ns / 1ps
interface qvc_in_if;
  logic                        valid;
  logic                        ready;
  logic [qvc_pkg::OP_W-1:0]    operation;
  logic [qvc_pkg::LVL_W-1:0]   level;
  modport source (output valid, operation, level, input ready);
  modport sink   (input valid, operation, level, output ready);
endinterface

interface qvc_out_if;
  logic                              valid;
  logic                              ready;
  logic [qvc_pkg::VOL_W-1:0]         volume;
  logic                              volume_changed;
  logic signed [qvc_pkg::DIR_W-1:0]  direction;
  logic                              muted;
  modport source (output valid, volume, volume_changed, direction, muted, input ready);
  modport sink   (input valid, volume, volume_changed, direction, muted, output ready);
endinterface

interface qvc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [qvc_pkg::CFG_IDX_W-1:0]     index;
  logic [qvc_pkg::CFG_DAT_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/qvc_mul.sv */
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
`timescale 1ns / 1ps
module qvc_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  qvc_pkg::mul_req_t req,
  output qvc_pkg::mul_rsp_t rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [qvc_pkg::MUL_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [qvc_pkg::PROD_W-1:0]        acc_r, acc_nxt;
  logic [qvc_pkg::PROD_W-1:0]        mcand_r, mcand_nxt;
  logic [qvc_pkg::PCT_W-1:0]         mplier_r, mplier_nxt;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    if (req.start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = qvc_pkg::MUL_CNT_W'(qvc_pkg::PCT_W - 1);
      acc_nxt    = '0;
      mcand_nxt  = qvc_pkg::PROD_W'(req.multiplicand);
      mplier_nxt = req.multiplier;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = {mcand_r[qvc_pkg::PROD_W-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[qvc_pkg::PCT_W-1:1]};
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

/* hw/rtl/qvc_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module qvc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  qvc_pkg::div_req_t req,
  output qvc_pkg::div_rsp_t rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [qvc_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [qvc_pkg::PROD_W-1:0]        quo_r, quo_nxt;
  logic [qvc_pkg::VOL_W-1:0]         rem_r, rem_nxt;
  logic [qvc_pkg::VOL_W-1:0]         dvsr_r, dvsr_nxt;
  logic [qvc_pkg::VOL_W:0]           trial;
  logic [qvc_pkg::VOL_W:0]           diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    trial    = {rem_r, quo_r[qvc_pkg::PROD_W-1]};
    diff     = trial - {1'b0, dvsr_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = qvc_pkg::DIV_CNT_W'(qvc_pkg::PROD_W - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvsr_nxt = req.divisor;
    end else if (busy_r) begin
      // Shift the next dividend bit in; keep the difference when it fits.
      if (trial >= {1'b0, dvsr_r}) begin
        rem_nxt = diff[qvc_pkg::VOL_W-1:0];
        quo_nxt = {quo_r[qvc_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[qvc_pkg::VOL_W-1:0];
        quo_nxt = {quo_r[qvc_pkg::PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* hw/rtl/quadrature_volume_control_core.sv */
// Top level of the quadrature volume control: event decode, sequencer, volume state.
`timescale 1ns / 1ps
// Events that do not touch the volume (pin moves below the threshold, releases,
//   timeouts) go straight to the result register; a volume step, mute or unmute
//   runs the 7-bit serial multiplier, then the 23-bit serial divider, and its
//   result is registered when the divider is done. No new event is taken meanwhile.
// Throughput: one simple event per cycle while the result slot is free.
// Reset (synchronous, rst_n low): registers to 255/4/0, pins, phase, count and
//   saved percent to zero, volume to the reset value of initial_volume (zero).
module quadrature_volume_control_core (
  input  logic            clk,
  input  logic            rst_n,
  qvc_in_if.sink          in_chan,
  qvc_out_if.source       out_chan,
  qvc_cfg_if.sink         cfg_chan
);

  // Configuration. initial_volume only matters at reset, where it is itself
  // reset to zero, so a write to it is taken and has no further effect.
  logic [qvc_pkg::VOL_W-1:0]   vmax_r;
  logic [qvc_pkg::THR_W-1:0]   thr_r;

  // Event state.
  logic                          pin_a_r, pin_a_nxt;
  logic                          pin_b_r, pin_b_nxt;
  logic [qvc_pkg::PHASE_W-1:0]   last_phase_r, last_phase_nxt;
  logic [qvc_pkg::CNT_W-1:0]     step_count_r, step_count_nxt;
  logic [qvc_pkg::PCT_W-1:0]     saved_r, saved_nxt;
  logic [qvc_pkg::VOL_W-1:0]     volume_r, volume_nxt;

  // Sequencer.
  qvc_pkg::state_t               state_r, state_nxt;
  qvc_pkg::action_t              action_r, action_dec;
  logic signed [qvc_pkg::DIR_W-1:0] dir_r, dir_dec;

  // Result register.
  logic                          out_valid_r, out_valid_nxt;
  logic [qvc_pkg::VOL_W-1:0]     out_volume_r, out_volume_nxt;
  logic                          out_changed_r, out_changed_nxt;
  logic signed [qvc_pkg::DIR_W-1:0] out_dir_r, out_dir_nxt;
  logic                          out_muted_r, out_muted_nxt;

  logic                          in_ready;
  logic                          accept;
  logic                          out_free;
  logic                          finish;

  qvc_pkg::mul_req_t             mul_req;
  qvc_pkg::mul_rsp_t             mul_rsp;
  qvc_pkg::div_req_t             div_req;
  qvc_pkg::div_rsp_t             div_rsp;

  logic                          op_ok;
  logic [qvc_pkg::PHASE_W-1:0]   phase;
  logic signed [qvc_pkg::DIR_W-1:0] mv;
  logic [qvc_pkg::CNT_W-1:0]     count_inc;

  logic [qvc_pkg::PROD_W:0]      vol_ext;
  logic [qvc_pkg::PROD_W:0]      q_ext;
  logic [qvc_pkg::PROD_W:0]      raw_vol;
  logic [qvc_pkg::VOL_W-1:0]     fin_volume;
  logic [qvc_pkg::PCT_W-1:0]     fin_saved;

  qvc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  qvc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration writes are always taken.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmax_r <= qvc_pkg::VOLUME_MAX_RST;
      thr_r  <= qvc_pkg::STEP_THRESHOLD_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        qvc_pkg::CFG_VOLUME_MAX:     vmax_r <= cfg_chan.data[qvc_pkg::VOL_W-1:0];
        qvc_pkg::CFG_STEP_THRESHOLD: thr_r  <= cfg_chan.data[qvc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a new request only when idle and the result slot is empty or draining.
  assign out_free = !out_valid_r || out_chan.ready;
  assign accept   = in_chan.valid && in_ready;
  assign finish   = (state_r == qvc_pkg::ST_DIV) && div_rsp.done;

  // Decode the incoming event: pin update, phase move, step count, action.
  always_comb begin
    op_ok          = ((in_chan.level == qvc_pkg::LVL_LOW) ||
                      (in_chan.level == qvc_pkg::LVL_HIGH)) &&
                     ((in_chan.operation == qvc_pkg::OP_PIN_A) ||
                      (in_chan.operation == qvc_pkg::OP_PIN_B) ||
                      (in_chan.operation == qvc_pkg::OP_BUTTON));
    pin_a_nxt      = pin_a_r;
    pin_b_nxt      = pin_b_r;
    last_phase_nxt = last_phase_r;
    step_count_nxt = step_count_r;
    action_dec     = qvc_pkg::ACT_NONE;
    dir_dec        = qvc_pkg::DIR_NONE;
    phase          = {pin_a_r, pin_b_r};
    mv             = qvc_pkg::DIR_NONE;
    count_inc      = step_count_r + 1'b1;
    if (op_ok) begin
      if (in_chan.operation == qvc_pkg::OP_BUTTON) begin
        // Press toggles between mute (save percent) and restore.
        if (in_chan.level == qvc_pkg::LVL_HIGH) begin
          action_dec = (saved_r == '0) ? qvc_pkg::ACT_MUTE : qvc_pkg::ACT_UNMUTE;
        end
      end else begin
        if (in_chan.operation == qvc_pkg::OP_PIN_A) begin
          pin_a_nxt = in_chan.level[0];
        end else begin
          pin_b_nxt = in_chan.level[0];
        end
        phase = {pin_a_nxt, pin_b_nxt};
        mv    = qvc_pkg::move_lookup({last_phase_r, phase});
        // Invalid move: keep phase and count, the pin level still updates.
        if (mv != qvc_pkg::DIR_NONE) begin
          dir_dec        = mv;
          last_phase_nxt = phase;
          step_count_nxt = count_inc;
          if (count_inc > qvc_pkg::CNT_W'(thr_r)) begin
            step_count_nxt = '0;
            action_dec     = (mv == qvc_pkg::DIR_UP) ? qvc_pkg::ACT_STEP_UP
                                                     : qvc_pkg::ACT_STEP_DN;
          end
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qvc_pkg::ST_IDLE: begin
        if (accept && (action_dec != qvc_pkg::ACT_NONE)) begin
          state_nxt = qvc_pkg::ST_MUL;
        end
      end
      qvc_pkg::ST_MUL: begin
        if (mul_rsp.done) begin
          state_nxt = qvc_pkg::ST_DIV;
        end
      end
      qvc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = qvc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qvc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and arithmetic unit launches.
  // Mute:    volume * 100 / max(volume_max, 1)
  // Unmute:  saved * volume_max / 100
  // Step:    volume_max * 1 / 100
  always_comb begin
    in_ready             = 1'b0;
    mul_req.start        = 1'b0;
    mul_req.multiplicand = vmax_r;
    mul_req.multiplier   = qvc_pkg::UNIT_FACTOR;
    div_req.start        = 1'b0;
    div_req.dividend     = mul_rsp.product;
    div_req.divisor      = qvc_pkg::VOL_W'(qvc_pkg::PERCENT_SCALE);
    unique case (state_r)
      qvc_pkg::ST_IDLE: begin
        in_ready      = out_free;
        mul_req.start = in_chan.valid && out_free && (action_dec != qvc_pkg::ACT_NONE);
        if (action_dec == qvc_pkg::ACT_MUTE) begin
          mul_req.multiplicand = volume_r;
          mul_req.multiplier   = qvc_pkg::PERCENT_SCALE;
        end else if (action_dec == qvc_pkg::ACT_UNMUTE) begin
          mul_req.multiplier   = saved_r;
        end
      end
      qvc_pkg::ST_MUL: begin
        div_req.start = mul_rsp.done;
        if (action_r == qvc_pkg::ACT_MUTE) begin
          // A zero maximum divides as one.
          div_req.divisor = (vmax_r == '0) ? qvc_pkg::VOL_W'(1) : vmax_r;
        end
      end
      qvc_pkg::ST_DIV: ;
      default: ;
    endcase
  end

  // Finish the arithmetic: add or subtract the quotient, clamp to volume_max,
  // or save the saturated percent on mute.
  always_comb begin
    vol_ext    = (qvc_pkg::PROD_W + 1)'(volume_r);
    q_ext      = {1'b0, div_rsp.quotient};
    fin_saved  = '0;
    raw_vol    = '0;
    unique case (action_r)
      qvc_pkg::ACT_MUTE: begin
        fin_saved = (div_rsp.quotient > qvc_pkg::PROD_W'(qvc_pkg::PERCENT_LIMIT))
                    ? qvc_pkg::PERCENT_LIMIT
                    : div_rsp.quotient[qvc_pkg::PCT_W-1:0];
      end
      qvc_pkg::ACT_STEP_DN: begin
        raw_vol = (vol_ext > q_ext) ? (vol_ext - q_ext) : '0;
        fin_saved = saved_r;
      end
      qvc_pkg::ACT_STEP_UP: begin
        raw_vol   = vol_ext + q_ext;
        fin_saved = saved_r;
      end
      qvc_pkg::ACT_UNMUTE: begin
        raw_vol = vol_ext + q_ext;
      end
      default: begin
        fin_saved = saved_r;
      end
    endcase
    fin_volume = (raw_vol > (qvc_pkg::PROD_W + 1)'(vmax_r)) ? vmax_r
                                                            : raw_vol[qvc_pkg::VOL_W-1:0];
  end

  // Volume, saved percent and result register updates.
  always_comb begin
    volume_nxt      = volume_r;
    saved_nxt       = saved_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_volume_nxt  = out_volume_r;
    out_changed_nxt = out_changed_r;
    out_dir_nxt     = out_dir_r;
    out_muted_nxt   = out_muted_r;
    if (accept && (action_dec == qvc_pkg::ACT_NONE)) begin
      out_valid_nxt   = 1'b1;
      out_volume_nxt  = volume_r;
      out_changed_nxt = 1'b0;
      out_dir_nxt     = dir_dec;
      out_muted_nxt   = (saved_r != '0);
    end else if (finish) begin
      volume_nxt      = fin_volume;
      saved_nxt       = fin_saved;
      out_valid_nxt   = 1'b1;
      out_volume_nxt  = fin_volume;
      out_changed_nxt = 1'b1;
      out_dir_nxt     = dir_r;
      out_muted_nxt   = (fin_saved != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= qvc_pkg::ST_IDLE;
      action_r     <= qvc_pkg::ACT_NONE;
      pin_a_r      <= 1'b0;
      pin_b_r      <= 1'b0;
      last_phase_r <= '0;
      step_count_r <= '0;
      saved_r      <= '0;
      volume_r     <= qvc_pkg::INITIAL_VOLUME_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      saved_r     <= saved_nxt;
      volume_r    <= volume_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        action_r     <= action_dec;
        pin_a_r      <= pin_a_nxt;
        pin_b_r      <= pin_b_nxt;
        last_phase_r <= last_phase_nxt;
        step_count_r <= step_count_nxt;
      end
    end
  end

  // Payload: hold the direction across the arithmetic, and the result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      dir_r <= dir_dec;
    end
    out_volume_r  <= out_volume_nxt;
    out_changed_r <= out_changed_nxt;
    out_dir_r     <= out_dir_nxt;
    out_muted_r   <= out_muted_nxt;
  end

  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.volume         = out_volume_r;
  assign out_chan.volume_changed = out_changed_r;
  assign out_chan.direction      = out_dir_r;
  assign out_chan.muted          = out_muted_r;

endmodule

/* dv/qvc_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the volume control: predicts every result and compares it with the block.
module qvc_result_checker
  import qvc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  qvc_in_if    ev_mon,
  qvc_out_if   res_mon,
  qvc_cfg_if   reg_mon,
  output int   mismatch_count,
  output int   outstanding
);

  typedef struct packed {
    logic [VOL_W-1:0]        volume;
    logic                    changed;
    logic signed [DIR_W-1:0] direction;
    logic                    muted;
  } vol_result_t;

  // Detent decode indexed by {previous phase, new phase}.
  localparam logic signed [DIR_W-1:0] DETENT_MOVES [16] = '{
    DIR_NONE, DIR_DN,   DIR_UP,   DIR_NONE, DIR_UP,   DIR_NONE, DIR_NONE, DIR_DN,
    DIR_DN,   DIR_NONE, DIR_NONE, DIR_UP,   DIR_NONE, DIR_UP,   DIR_DN,   DIR_NONE
  };

  logic [VOL_W-1:0]   max_vol;
  logic [THR_W-1:0]   detent_limit;
  logic               a_seen;
  logic               b_seen;
  logic [PHASE_W-1:0] prev_phase;
  logic [CNT_W-1:0]   detent_cnt;
  logic [PCT_W-1:0]   held_pct;
  logic [VOL_W-1:0]   cur_vol;
  vol_result_t        volume_q[$];
  int                 fault_total = 0;

  assign mismatch_count = fault_total;

  function automatic logic [VOL_W-1:0] clamp_to_max(input longint unsigned v);
    return (v > max_vol) ? max_vol : VOL_W'(v);
  endfunction

  task automatic predict_event(input logic [OP_W-1:0] op, input logic [LVL_W-1:0] lvl,
                               output vol_result_t r);
    logic [PHASE_W-1:0]      ph;
    logic signed [DIR_W-1:0] mv;
    longint unsigned         wide;
    longint unsigned         scale;
    r = '0;
    if (lvl inside {LVL_LOW, LVL_HIGH}) begin
      case (op)
        OP_BUTTON: begin
          if (lvl == LVL_HIGH) begin
            if (held_pct == '0) begin
              // mute: remember the volume as a percent of max, saturated
              scale = (max_vol == '0) ? 64'd1 : 64'(max_vol);
              wide = 64'(cur_vol) * PERCENT_SCALE / scale;
              held_pct = (wide > 64'(PERCENT_LIMIT)) ? PERCENT_LIMIT : PCT_W'(wide);
              cur_vol = '0;
            end else begin
              wide = 64'(cur_vol) + 64'(held_pct) * max_vol / PERCENT_SCALE;
              cur_vol = clamp_to_max(wide);
              held_pct = '0;
            end
            r.changed = 1'b1;
          end
        end
        OP_PIN_A, OP_PIN_B: begin
          if (op == OP_PIN_A) a_seen = lvl[0];
          else b_seen = lvl[0];
          ph = {a_seen, b_seen};
          mv = DETENT_MOVES[{prev_phase, ph}];
          if (mv != DIR_NONE) begin
            r.direction = mv;
            prev_phase = ph;
            detent_cnt = detent_cnt + 1'b1;
            if (detent_cnt > detent_limit) begin
              scale = 64'(max_vol) / PERCENT_SCALE;
              detent_cnt = '0;
              if (mv == DIR_UP) wide = 64'(cur_vol) + scale;
              else wide = (64'(cur_vol) > scale) ? 64'(cur_vol) - scale : 64'd0;
              cur_vol = clamp_to_max(wide);
              r.changed = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    r.volume = cur_vol;
    r.muted = (held_pct != '0);
  endtask

  task automatic flag_mismatch(input string field, input longint want_v, input longint got_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    fault_total++;
  endtask

  always @(posedge clk) begin
    vol_result_t want;
    vol_result_t got;
    if (!rst_n) begin
      max_vol      = VOLUME_MAX_RST;
      detent_limit = STEP_THRESHOLD_RST;
      a_seen       = 1'b0;
      b_seen       = 1'b0;
      prev_phase   = '0;
      detent_cnt   = '0;
      held_pct     = '0;
      cur_vol      = INITIAL_VOLUME_RST;
      volume_q.delete();
    end else begin
      // retire first: a result leaving at this edge belongs to an older request
      if (res_mon.valid && res_mon.ready) begin
        got = {res_mon.volume, res_mon.volume_changed, res_mon.direction, res_mon.muted};
        if (volume_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual volume %0d",
                   $time, got.volume);
          fault_total++;
        end else begin
          want = volume_q.pop_front();
          if (got.volume !== want.volume)
            flag_mismatch("volume", want.volume, got.volume);
          if (got.changed !== want.changed)
            flag_mismatch("volume_changed", want.changed, got.changed);
          if (got.direction !== want.direction)
            flag_mismatch("direction", $signed(want.direction), $signed(got.direction));
          if (got.muted !== want.muted)
            flag_mismatch("muted", want.muted, got.muted);
        end
      end
      if (reg_mon.valid && reg_mon.ready) begin
        case (reg_mon.index)
          CFG_VOLUME_MAX:     max_vol = reg_mon.data;
          CFG_STEP_THRESHOLD: detent_limit = reg_mon.data[THR_W-1:0];
          // initial volume only takes effect at reset, where it is back at zero
          CFG_INITIAL_VOLUME: ;
          default: ;
        endcase
      end
      if (ev_mon.valid && ev_mon.ready) begin
        predict_event(ev_mon.operation, ev_mon.level, want);
        volume_q.push_back(want);
      end
    end
    outstanding <= volume_q.size();
  end

endmodule

/* dv/tb_quadrature_volume_control_core.sv */
`timescale 1ns / 1ps
// Testbench top for the quadrature volume control: stimulus, result pacing and verdict.
module tb_quadrature_volume_control_core;
  import qvc_pkg::*;

  // Codes the package leaves unnamed: an unused operation and the ignored levels.
  localparam logic [OP_W-1:0]      OP_UNUSED     = 2'd3;
  localparam logic [LVL_W-1:0]     LVL_TIMEOUT   = 2'd2;
  localparam logic [LVL_W-1:0]     LVL_UNDEF     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 5;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT  = 5000;

  logic clk = 1'b0;
  logic rst_n;

  // Shared knobs between the request driver and the result pacer.
  logic no_idle      = 1'b0;
  logic hold_off_req = 1'b0;

  // Pin levels as last sent, used to build clean quadrature sequences.
  logic pin_a = 1'b0;
  logic pin_b = 1'b0;

  int mismatch_count;
  int outstanding;
  int idle_cycles = 0;

  qvc_in_if  ev_ch ();
  qvc_out_if res_ch ();
  qvc_cfg_if reg_ch ();

  quadrature_volume_control_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (ev_ch),
    .out_chan (res_ch),
    .cfg_chan (reg_ch)
  );

  qvc_result_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .ev_mon         (ev_ch),
    .res_mon        (res_ch),
    .reg_mon        (reg_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: count cycles without any handshake and abort on a hang.
  always @(posedge clk) begin
    if (!rst_n || (ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (reg_ch.valid && reg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_span();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
  endfunction

  // Result pacer: ready stretches and stalls of random length, plus one long
  // hold-off on request so the block backs up and stalls its input.
  initial begin : result_pacer
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (no_idle || $urandom_range(0, 2) != 0) begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b0;
        repeat (idle_span()) @(posedge clk);
      end
    end
  end

  // Offer one pin event and hold it until accepted. Keep valid high into the
  // next request unless a gap is drawn, so valid never drops and rises in one step.
  task automatic send_event(input logic [OP_W-1:0] op, input logic [LVL_W-1:0] lvl);
    ev_ch.valid     <= 1'b1;
    ev_ch.operation <= op;
    ev_ch.level     <= lvl;
    do @(posedge clk); while (!ev_ch.ready);
    if (lvl inside {LVL_LOW, LVL_HIGH}) begin
      if (op == OP_PIN_A) pin_a = lvl[0];
      if (op == OP_PIN_B) pin_b = lvl[0];
    end
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      ev_ch.valid <= 1'b0;
      repeat (idle_span()) @(posedge clk);
    end
  endtask

  // Advance the encoder one quarter detent. Clockwise walks the phase
  // 0 -> 2 -> 3 -> 1 -> 0: toggle A when the pins agree, B when they differ.
  task automatic turn_detent(input bit clockwise);
    if ((pin_a == pin_b) == clockwise) send_event(OP_PIN_A, pin_a ? LVL_LOW : LVL_HIGH);
    else send_event(OP_PIN_B, pin_b ? LVL_LOW : LVL_HIGH);
  endtask

  // Mostly clean rotation with a direction bias; the rest is button activity,
  // repeated levels (invalid moves), timeouts and unused codes.
  task automatic send_random_event(input int unsigned cw_pct);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      turn_detent($urandom_range(0, 99) < cw_pct);
    end else if (pick < 80) begin
      send_event(OP_BUTTON, LVL_HIGH);
    end else if (pick < 86) begin
      send_event(OP_BUTTON, LVL_LOW);
    end else if (pick < 91) begin
      if ($urandom_range(0, 1) == 1) send_event(OP_PIN_A, pin_a ? LVL_HIGH : LVL_LOW);
      else send_event(OP_PIN_B, pin_b ? LVL_HIGH : LVL_LOW);
    end else if (pick < 96) begin
      send_event(OP_W'($urandom_range(0, 3)), ($urandom_range(0, 1) == 1) ? LVL_TIMEOUT
                                                                          : LVL_UNDEF);
    end else begin
      send_event(OP_UNUSED, LVL_W'($urandom_range(0, 3)));
    end
  endtask

  // Drop the request valid and wait until every predicted result has come back.
  // The extra edge lets the checker count a request accepted at this very edge.
  task automatic settle();
    ev_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write all registers back to back, plus the spare index, which must be ignored.
  // Junk in the unused high bits of the threshold write must be dropped too.
  task automatic program_regs(input logic [VOL_W-1:0] vmax, input logic [THR_W-1:0] thr,
                              input logic [VOL_W-1:0] init);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= CFG_VOLUME_MAX;
    reg_ch.data  <= vmax;
    do @(posedge clk); while (!reg_ch.ready);
    reg_ch.index <= CFG_STEP_THRESHOLD;
    reg_ch.data  <= {(CFG_DAT_W - THR_W)'($urandom), thr};
    do @(posedge clk); while (!reg_ch.ready);
    reg_ch.index <= CFG_INITIAL_VOLUME;
    reg_ch.data  <= init;
    do @(posedge clk); while (!reg_ch.ready);
    reg_ch.index <= CFG_IDX_SPARE;
    reg_ch.data  <= CFG_DAT_W'($urandom);
    do @(posedge clk); while (!reg_ch.ready);
    reg_ch.valid <= 1'b0;
  endtask

  // One random phase: drain, reprogram, then a burst of random requests.
  task automatic run_phase(input logic [VOL_W-1:0] vmax, input logic [THR_W-1:0] thr,
                           input logic [VOL_W-1:0] init, input int unsigned cw_pct,
                           input bit steady, input bit squeeze, input int unsigned count);
    settle();
    program_regs(vmax, thr, init);
    no_idle = steady;
    if (squeeze) hold_off_req = 1'b1;
    repeat (count) send_random_event(cw_pct);
  endtask

  initial begin : stimulus
    rst_n           <= 1'b0;
    ev_ch.valid     <= 1'b0;
    ev_ch.operation <= OP_PIN_A;
    ev_ch.level     <= LVL_LOW;
    reg_ch.valid    <= 1'b0;
    reg_ch.index    <= CFG_VOLUME_MAX;
    reg_ch.data     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, at reset settings (max 255, threshold 4): release does nothing,
    // a press at zero volume saves zero percent and stays unmuted, ignored levels
    // and the unused operation, a repeated level (invalid move), then five
    // clockwise moves so the fifth one steps the volume up.
    send_event(OP_BUTTON, LVL_LOW);
    send_event(OP_BUTTON, LVL_HIGH);
    send_event(OP_PIN_A, LVL_TIMEOUT);
    send_event(OP_PIN_B, LVL_UNDEF);
    send_event(OP_UNUSED, LVL_HIGH);
    send_event(OP_PIN_A, LVL_LOW);
    repeat (5) turn_detent(1'b1);

    // Full-scale max with threshold zero: every move steps; then mute with a
    // nonzero percent, unmute, and one step down.
    settle();
    program_regs(16'hFFFF, 4'd0, 16'hFFFF);
    repeat (3) turn_detent(1'b1);
    send_event(OP_BUTTON, LVL_HIGH);
    send_event(OP_BUTTON, LVL_HIGH);
    turn_detent(1'b0);

    // Zero max: the volume now sits above max, so the mute percent saturates;
    // unmuting adds nothing and clamps to zero.
    settle();
    program_regs(16'd0, 4'd15, 16'd0);
    send_event(OP_BUTTON, LVL_HIGH);
    send_event(OP_BUTTON, LVL_HIGH);
    turn_detent(1'b0);

    // Random phases across the register ranges. The second one climbs at full
    // scale under a long result hold-off, the third then starts above max.
    run_phase(16'd255, 4'd4, VOL_W'($urandom), 70, 1'b0, 1'b0, 100);
    run_phase(16'hFFFF, 4'd1, 16'hFFFF, 92, 1'b0, 1'b1, 140);
    run_phase(16'd1000, 4'd2, 16'd0, 50, 1'b0, 1'b0, 90);
    run_phase(16'd1, 4'd15, VOL_W'($urandom), 60, 1'b1, 1'b0, 80);
    run_phase(16'd100, 4'd0, VOL_W'($urandom), 40, 1'b0, 1'b0, 90);
    run_phase(16'd0, 4'd3, VOL_W'($urandom), 50, 1'b0, 1'b0, 60);
    run_phase(16'd40000, 4'd7, 16'd0, 25, 1'b0, 1'b0, 90);
    run_phase(VOL_W'($urandom_range(1, 65535)), THR_W'($urandom_range(0, 15)),
              VOL_W'($urandom), 50, 1'b0, 1'b0, 80);

    // Drain, then watch a little longer for any stray result.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/qvc_pkg.sv
hw/rtl/qvc_if.sv
hw/rtl/qvc_mul.sv
hw/rtl/qvc_div.sv
hw/rtl/quadrature_volume_control_core.sv
dv/qvc_result_checker.sv
dv/tb_quadrature_volume_control_core.sv
